// ----- rtl/rip_pkg.sv -----
// Shared constants and types for the RGB intensity to pixel packer.
`default_nettype none

package rip_pkg;

  localparam int LEVEL_W          = 10;
  localparam int FULL_SCALE       = 1000;
  localparam int BITS_W           = 4;
  localparam int POS_W            = 5;
  localparam int POS_ENTRIES      = 8;
  localparam int POS_REG_W        = POS_W * POS_ENTRIES;
  localparam int IDX_W            = 3;
  localparam int PIXEL_W          = 32;
  localparam int HALF_PIXEL_W     = 16;
  localparam int CHANNELS         = 3;
  localparam int MAX_CHANNEL_BITS = 8;

  // floor(p / 1000) == (p * RECIP_MULT) >> RECIP_SHIFT for p < 2^18
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'((64'd1 << RECIP_SHIFT) / FULL_SCALE + 1);

  localparam logic [BITS_W-1:0] RED_BITS_RST   = BITS_W'(5);
  localparam logic [BITS_W-1:0] GREEN_BITS_RST = BITS_W'(6);
  localparam logic [BITS_W-1:0] BLUE_BITS_RST  = BITS_W'(5);

  typedef enum logic [IDX_W-1:0] {
    REG_RED_BITS        = 3'd0,
    REG_GREEN_BITS      = 3'd1,
    REG_BLUE_BITS       = 3'd2,
    REG_RED_POSITIONS   = 3'd3,
    REG_GREEN_POSITIONS = 3'd4,
    REG_BLUE_POSITIONS  = 3'd5,
    REG_DEPTH_MODE      = 3'd6
  } reg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/rgb_intensity_to_pixel_packer.sv -----
// RGB intensity to packed pixel converter, three-stage pipeline.
// An accepted start passes through valid1 and valid2 before it raises the done strobe.
// Throughput: one word per cycle; busy stays low, the pipeline is never held.
// Stages: saturate and scale by 2^n-1, divide by 1000 via reciprocal multiply,
// scatter bits to pixel positions. The receiver cannot stall the done strobe.
// Reset clears the pipeline valids and loads the register reset values.
`default_nettype none

module rgb_intensity_to_pixel_packer #(
  parameter int MAX_CHANNEL_BITS = rip_pkg::MAX_CHANNEL_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rip_pkg::LEVEL_W-1:0]    red_intensity,
  input  wire logic [rip_pkg::LEVEL_W-1:0]    green_intensity,
  input  wire logic [rip_pkg::LEVEL_W-1:0]    blue_intensity,
  input  wire logic                           wr_en,
  input  wire logic [rip_pkg::IDX_W-1:0]      wr_index,
  input  wire logic [rip_pkg::POS_REG_W-1:0]  wr_data,
  output logic                                done,
  output logic [rip_pkg::PIXEL_W-1:0]         pixel_value
);

  localparam int PW = rip_pkg::LEVEL_W + MAX_CHANNEL_BITS;
  localparam int NW = $clog2(MAX_CHANNEL_BITS + 1);
  localparam int WW = PW + rip_pkg::RECIP_W;

  logic [rip_pkg::BITS_W-1:0]    bits_cfg [rip_pkg::CHANNELS];
  logic [rip_pkg::POS_REG_W-1:0] pos_cfg  [rip_pkg::CHANNELS];
  logic                          depth_mode;

  logic [rip_pkg::LEVEL_W-1:0]   level    [rip_pkg::CHANNELS];
  logic [NW-1:0]                 nbits    [rip_pkg::CHANNELS];
  logic [PW-1:0]                 prod_next[rip_pkg::CHANNELS];
  logic [PW-1:0]                 prod     [rip_pkg::CHANNELS];
  logic [WW-1:0]                 wide     [rip_pkg::CHANNELS];
  logic [MAX_CHANNEL_BITS-1:0]   scaled   [rip_pkg::CHANNELS];
  logic [rip_pkg::PIXEL_W-1:0]   pixel_next;
  logic                          valid1;
  logic                          valid2;
  logic                          accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_cfg[0] <= rip_pkg::RED_BITS_RST;
      bits_cfg[1] <= rip_pkg::GREEN_BITS_RST;
      bits_cfg[2] <= rip_pkg::BLUE_BITS_RST;
      pos_cfg[0]  <= '0;
      pos_cfg[1]  <= '0;
      pos_cfg[2]  <= '0;
      depth_mode  <= 1'b0;
    end else if (wr_en) begin
      unique case (rip_pkg::reg_idx_t'(wr_index))
        rip_pkg::REG_RED_BITS:        bits_cfg[0] <= wr_data[rip_pkg::BITS_W-1:0];
        rip_pkg::REG_GREEN_BITS:      bits_cfg[1] <= wr_data[rip_pkg::BITS_W-1:0];
        rip_pkg::REG_BLUE_BITS:       bits_cfg[2] <= wr_data[rip_pkg::BITS_W-1:0];
        rip_pkg::REG_RED_POSITIONS:   pos_cfg[0]  <= wr_data;
        rip_pkg::REG_GREEN_POSITIONS: pos_cfg[1]  <= wr_data;
        rip_pkg::REG_BLUE_POSITIONS:  pos_cfg[2]  <= wr_data;
        rip_pkg::REG_DEPTH_MODE:      depth_mode  <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    level[0] = red_intensity;
    level[1] = green_intensity;
    level[2] = blue_intensity;
    for (int c = 0; c < rip_pkg::CHANNELS; c++) begin
      if (level[c] > rip_pkg::LEVEL_W'(rip_pkg::FULL_SCALE)) begin
        level[c] = rip_pkg::LEVEL_W'(rip_pkg::FULL_SCALE);
      end
      if (bits_cfg[c] > rip_pkg::BITS_W'(MAX_CHANNEL_BITS)) begin
        nbits[c] = NW'(MAX_CHANNEL_BITS);
      end else begin
        nbits[c] = NW'(bits_cfg[c]);
      end
      prod_next[c] = (PW'(level[c]) << nbits[c]) - PW'(level[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < rip_pkg::CHANNELS; c++) begin
      wide[c] = WW'(prod[c]) * WW'(rip_pkg::RECIP_MULT);
    end
  end

  always_comb begin
    pixel_next = '0;
    for (int c = 0; c < rip_pkg::CHANNELS; c++) begin
      for (int k = 0; k < MAX_CHANNEL_BITS; k++) begin
        if (scaled[c][k]) begin
          pixel_next = pixel_next |
            (rip_pkg::PIXEL_W'(1) << pos_cfg[c][k*rip_pkg::POS_W +: rip_pkg::POS_W]);
        end
      end
    end
    if (!depth_mode) begin
      pixel_next[rip_pkg::PIXEL_W-1:rip_pkg::HALF_PIXEL_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < rip_pkg::CHANNELS; c++) begin
      prod[c]   <= prod_next[c];
      scaled[c] <= wide[c][rip_pkg::RECIP_SHIFT +: MAX_CHANNEL_BITS];
    end
    pixel_value <= pixel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= accept;
      valid2 <= valid1;
      done   <= valid2;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rip_checker.sv -----
// Port-level checker for the RGB intensity to pixel packer, with its bind.
`default_nettype none

module rip_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  a_accept_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted word produced no done strobe");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##3 !done)
    else $error("done strobe without an accepted word");

  a_reset_clears_done: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done strobe right after reset");

endmodule

bind rgb_intensity_to_pixel_packer rip_checker u_rip_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

`default_nettype wire

// ----- sim/tb_rgb_intensity_to_pixel_packer.sv -----
// Testbench for the RGB intensity to pixel packer: directed and random colors, scoreboard check.
module tb_rgb_intensity_to_pixel_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import rip_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  localparam int PIPE_DRAIN = 6;
  localparam int DRAIN_LIMIT = 2000;
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS = 190;
  localparam int RED_CH = 0;
  localparam int GREEN_CH = 1;
  localparam int BLUE_CH = 2;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  class pixel_scoreboard;
    logic [BITS_W-1:0] chan_bits [CHANNELS];
    logic [POS_REG_W-1:0] chan_pos [CHANNELS];
    logic wide_mode;
    logic [PIXEL_W-1:0] expected_pixels [$];
    int mismatches;

    function new();
      chan_bits[RED_CH] = RED_BITS_RST;
      chan_bits[GREEN_CH] = GREEN_BITS_RST;
      chan_bits[BLUE_CH] = BLUE_BITS_RST;
      foreach (chan_pos[c]) chan_pos[c] = '0;
      wide_mode = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [POS_REG_W-1:0] data);
      case (idx)
        REG_RED_BITS: chan_bits[RED_CH] = data[BITS_W-1:0];
        REG_GREEN_BITS: chan_bits[GREEN_CH] = data[BITS_W-1:0];
        REG_BLUE_BITS: chan_bits[BLUE_CH] = data[BITS_W-1:0];
        REG_RED_POSITIONS: chan_pos[RED_CH] = data;
        REG_GREEN_POSITIONS: chan_pos[GREEN_CH] = data;
        REG_BLUE_POSITIONS: chan_pos[BLUE_CH] = data;
        REG_DEPTH_MODE: wide_mode = data[0];
        default: ;
      endcase
    endfunction

    function logic [PIXEL_W-1:0] scatter_channel(logic [LEVEL_W-1:0] level,
                                                 logic [BITS_W-1:0] nbits,
                                                 logic [POS_REG_W-1:0] pos);
      int unsigned lvl;
      int unsigned n;
      int unsigned scaled;
      logic [PIXEL_W-1:0] word;
      lvl = (level > FULL_SCALE) ? FULL_SCALE : level;
      n = (nbits > MAX_CHANNEL_BITS) ? MAX_CHANNEL_BITS : nbits;
      scaled = (((32'd1 << n) - 32'd1) * lvl) / FULL_SCALE;
      word = '0;
      for (int k = 0; k < n; k++) begin
        if (scaled[k]) word[pos[k*POS_W +: POS_W]] = 1'b1;
      end
      return word;
    endfunction

    function void note_color(logic [LEVEL_W-1:0] r, logic [LEVEL_W-1:0] g,
                             logic [LEVEL_W-1:0] b);
      logic [PIXEL_W-1:0] pixel;
      pixel = scatter_channel(r, chan_bits[RED_CH], chan_pos[RED_CH])
            | scatter_channel(g, chan_bits[GREEN_CH], chan_pos[GREEN_CH])
            | scatter_channel(b, chan_bits[BLUE_CH], chan_pos[BLUE_CH]);
      if (!wide_mode) pixel[PIXEL_W-1:HALF_PIXEL_W] = '0;
      expected_pixels.push_back(pixel);
    endfunction

    function void check_pixel(logic [PIXEL_W-1:0] actual);
      logic [PIXEL_W-1:0] want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected pixel %h, none pending", actual);
      end else begin
        want = expected_pixels.pop_front();
        if (actual !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("pixel mismatch: expected %h, got %h", want, actual);
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [LEVEL_W-1:0] red_intensity = '0;
  logic [LEVEL_W-1:0] green_intensity = '0;
  logic [LEVEL_W-1:0] blue_intensity = '0;
  logic wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [POS_REG_W-1:0] wr_data = '0;
  logic done;
  logic [PIXEL_W-1:0] pixel_value;

  pixel_scoreboard sb = new();

  rgb_intensity_to_pixel_packer DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red_intensity(red_intensity),
    .green_intensity(green_intensity),
    .blue_intensity(blue_intensity),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .pixel_value(pixel_value)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_color(red_intensity, green_intensity, blue_intensity);
      if (done) sb.check_pixel(pixel_value);
    end
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [POS_REG_W-1:0] rand_positions();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[POS_REG_W-1:0];
  endfunction

  function automatic logic [POS_REG_W-1:0] ramp_positions(int unsigned base);
    logic [POS_REG_W-1:0] p;
    for (int k = 0; k < POS_ENTRIES; k++) p[k*POS_W +: POS_W] = POS_W'(base + k);
    return p;
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    case ($urandom_range(0, 15))
      0: return LEVEL_W'(0);
      1: return LEVEL_W'(1);
      2: return LEVEL_W'(999);
      3: return LEVEL_W'(FULL_SCALE);
      4: return LEVEL_W'(1001);
      5: return '1;
      default: return LEVEL_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [BITS_W-1:0] rand_bits();
    if ($urandom_range(0, 9) < 8) return BITS_W'($urandom_range(0, MAX_CHANNEL_BITS));
    return BITS_W'($urandom_range(MAX_CHANNEL_BITS + 1, 15));
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic send_color(input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
                            input logic [LEVEL_W-1:0] b);
    logic taken;
    start <= 1'b1;
    red_intensity <= r;
    green_intensity <= g;
    blue_intensity <= b;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic settle();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [POS_REG_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setup(input logic [BITS_W-1:0] rb, input logic [BITS_W-1:0] gb,
                             input logic [BITS_W-1:0] bb, input logic [POS_REG_W-1:0] rp,
                             input logic [POS_REG_W-1:0] gp, input logic [POS_REG_W-1:0] bp,
                             input logic wide);
    logic [POS_REG_W-1:0] junk;
    settle();
    junk = rand_positions();
    program_reg(REG_RED_BITS, {junk[POS_REG_W-1:BITS_W], rb});
    junk = rand_positions();
    program_reg(REG_GREEN_BITS, {junk[POS_REG_W-1:BITS_W], gb});
    junk = rand_positions();
    program_reg(REG_BLUE_BITS, {junk[POS_REG_W-1:BITS_W], bb});
    program_reg(REG_RED_POSITIONS, rp);
    program_reg(REG_GREEN_POSITIONS, gp);
    program_reg(REG_BLUE_POSITIONS, bp);
    junk = rand_positions();
    program_reg(REG_DEPTH_MODE, {junk[POS_REG_W-1:1], wide});
    if ($urandom_range(0, 1)) program_reg(REG_UNUSED, rand_positions());
    wr_en <= 1'b0;
  endtask

  initial begin
    logic burst;
    int gap;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_color(0, 0, 0);
    send_color(1000, 1000, 1000);
    send_color(1023, 1023, 1023);
    send_color(1001, 999, 1);

    apply_setup(8, 8, 8, ramp_positions(0), ramp_positions(8), ramp_positions(16), 1'b1);
    send_color(1000, 0, 0);
    send_color(0, 1000, 0);
    send_color(0, 0, 1000);
    send_color(500, 250, 1023);
    send_color(1, 2, 3);

    apply_setup(0, 15, 8, ramp_positions(4), {POS_ENTRIES{5'd31}}, ramp_positions(12), 1'b0);
    send_color(1000, 1000, 1000);
    send_color(700, 3, 1023);
    send_color(0, 500, 999);

    apply_setup(0, 15, 8, ramp_positions(4), {POS_ENTRIES{5'd31}}, ramp_positions(12), 1'b1);
    send_color(1000, 1000, 1000);
    send_color(1023, 128, 640);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        apply_setup(8, 8, 8, rand_positions(), rand_positions(), rand_positions(), 1'b1);
      else if (phase == 1)
        apply_setup(0, 0, 0, rand_positions(), rand_positions(), rand_positions(), 1'b0);
      else
        apply_setup(rand_bits(), rand_bits(), rand_bits(), rand_positions(),
                    rand_positions(), rand_positions(), 1'($urandom_range(0, 1)));
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_color(rand_level(), rand_level(), rand_level());
        gap = burst ? 0 : gap_length();
        if (gap > 0) hold_off(gap);
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
